>>> hw/rtl/xtea_pkg.sv
// Shared types, constants and round functions for the XTEA block cipher.
package xtea_pkg;

   // Round constant and the width of one data word
   localparam int unsigned WORD_W = 32;
   localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

   // Register index of the configuration port
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] KEY_WORD0 = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] KEY_WORD1 = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] KEY_WORD2 = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] KEY_WORD3 = 8'd3;

   // Direction selector
   localparam logic FUNC_ENCIPHER = 1'b0;
   localparam logic FUNC_DECIPHER = 1'b1;

   // Input item
   typedef struct packed {
      logic              func;
      logic [WORD_W-1:0] block_low;
      logic [WORD_W-1:0] block_high;
   } req_type;

   // Result item
   typedef struct packed {
      logic [WORD_W-1:0] result_low;
      logic [WORD_W-1:0] result_high;
   } rsp_type;

   // n * delta modulo 2^32; only ever called on elaboration constants
   function automatic logic [WORD_W-1:0] sum_at(input int unsigned n);
      logic [2*WORD_W-1:0] prod;
      prod = 64'(n) * 64'(DELTA);
      return prod[WORD_W-1:0];
   endfunction

   // XTEA mixing term of one half cycle
   function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v,
                                             input logic [WORD_W-1:0] sum,
                                             input logic [WORD_W-1:0] k);
      return (((v << 4) ^ (v >> 5)) + v) ^ (sum + k);
   endfunction

endpackage

>>> hw/rtl/xtea_block_cipher.sv
// XTEA block cipher top level: fully pipelined, one half cycle per stage.
//
// Takes one 64-bit block per clock while the output is not stalled and
// returns it enciphered or deciphered under the 128-bit key held in the four
// key registers. The rounds are unrolled into 2*ROUNDS register stages, one
// half cycle (one mix term and one add or subtract) per stage, so a new item
// can enter every cycle while the output is not stalled. The running sum of
// each stage is a constant, chosen by the direction bit. When the output item
// is stalled the whole pipeline holds; bubbles are not squeezed out. Key
// registers may only be written while the pipeline is empty.
module xtea_block_cipher #(
   parameter int unsigned ROUNDS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_valid,
   output logic                              req_stall,
   input  xtea_pkg::req_type                 req_data,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output xtea_pkg::rsp_type                 rsp_data,
   // key register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [xtea_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [xtea_pkg::WORD_W-1:0]       csr_data
);

   localparam int unsigned STAGES = 2 * ROUNDS;

   logic [xtea_pkg::WORD_W-1:0] key_ff [4];

   logic [STAGES-1:0]           valid_ff;
   logic [STAGES-1:0]           valid_in;
   logic [STAGES-1:0]           func_ff;
   logic [STAGES-1:0]           func_in;
   logic [xtea_pkg::WORD_W-1:0] a_ff [STAGES];
   logic [xtea_pkg::WORD_W-1:0] a_in [STAGES];
   logic [xtea_pkg::WORD_W-1:0] b_ff [STAGES];
   logic [xtea_pkg::WORD_W-1:0] b_in [STAGES];

   logic advance;

   // whole pipeline moves unless the finished item is held
   assign advance   = !(valid_ff[STAGES-1] && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= '0;
         key_ff[1] <= '0;
         key_ff[2] <= '0;
         key_ff[3] <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            xtea_pkg::KEY_WORD0: key_ff[0] <= csr_data;
            xtea_pkg::KEY_WORD1: key_ff[1] <= csr_data;
            xtea_pkg::KEY_WORD2: key_ff[2] <= csr_data;
            xtea_pkg::KEY_WORD3: key_ff[3] <= csr_data;
            default: ;  // other indexes are ignored
         endcase
      end
   end

   // one half cycle per stage
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int unsigned RND  = s / 2;
      localparam bit          HALF = (s % 2) == 1;
      localparam logic [xtea_pkg::WORD_W-1:0] ENC_SUM =
         xtea_pkg::sum_at(HALF ? RND + 1 : RND);
      localparam logic [xtea_pkg::WORD_W-1:0] DEC_SUM =
         xtea_pkg::sum_at(HALF ? ROUNDS - RND - 1 : ROUNDS - RND);
      // first half of an encipher cycle and second half of a decipher
      // cycle touch the low word, with the key picked by sum bits 1:0
      localparam logic [1:0] ENC_KEY = HALF ? ENC_SUM[12:11] : ENC_SUM[1:0];
      localparam logic [1:0] DEC_KEY = HALF ? DEC_SUM[1:0] : DEC_SUM[12:11];

      logic                        src_valid;
      logic                        src_func;
      logic [xtea_pkg::WORD_W-1:0] src_a;
      logic [xtea_pkg::WORD_W-1:0] src_b;
      logic                        upd_a;
      logic [xtea_pkg::WORD_W-1:0] sum;
      logic [xtea_pkg::WORD_W-1:0] key;
      logic [xtea_pkg::WORD_W-1:0] term;
      logic [xtea_pkg::WORD_W-1:0] dst;
      logic [xtea_pkg::WORD_W-1:0] upd;

      if (s == 0) begin : g_first
         assign src_valid = req_valid;
         assign src_func  = req_data.func;
         assign src_a     = req_data.block_low;
         assign src_b     = req_data.block_high;
      end else begin : g_next
         assign src_valid = valid_ff[s-1];
         assign src_func  = func_ff[s-1];
         assign src_a     = a_ff[s-1];
         assign src_b     = b_ff[s-1];
      end

      // which word this stage updates and with which sum and key
      assign upd_a = (src_func == HALF);
      assign sum   = (src_func == xtea_pkg::FUNC_DECIPHER) ? DEC_SUM : ENC_SUM;
      assign key   = (src_func == xtea_pkg::FUNC_DECIPHER) ? key_ff[DEC_KEY]
                                                           : key_ff[ENC_KEY];
      assign term  = xtea_pkg::mix(upd_a ? src_b : src_a, sum, key);
      assign dst   = upd_a ? src_a : src_b;
      assign upd   = (src_func == xtea_pkg::FUNC_DECIPHER) ? dst - term : dst + term;

      assign valid_in[s] = src_valid;
      assign func_in[s]  = src_func;
      assign a_in[s]     = upd_a ? upd : src_a;
      assign b_in[s]     = upd_a ? src_b : upd;
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         func_ff <= func_in;
         a_ff    <= a_in;
         b_ff    <= b_in;
      end
   end

   // last stage is the output register
   assign rsp_valid            = valid_ff[STAGES-1];
   assign rsp_data.result_low  = a_ff[STAGES-1];
   assign rsp_data.result_high = b_ff[STAGES-1];

endmodule
